### design/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the terminal line editor
// Command, result kind and end reason codes, line store sizing, byte codes.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int CAP_W      = 9;
    localparam int HEAD_N     = 4;

    typedef enum logic [1:0] {
        CMD_CHAR   = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_RD_ERR = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_RDATA = 2'd2,
        KIND_RSVD  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        END_ENTER  = 2'd0,
        END_INTR   = 2'd1,
        END_EXIT   = 2'd2,
        END_CANCEL = 2'd3
    } t_reason;

    localparam logic [7:0] CH_ETX   = 8'd3;
    localparam logic [7:0] CH_EOT   = 8'd4;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_C     = 8'h43;

    localparam logic [7:0] EXIT_WORD [HEAD_N] = '{8'h65, 8'h78, 8'h69, 8'h74};

endpackage

### design/tle_if.sv
// ----------------------------------------------------------------------------
// tle_if: valid/ready channels of the terminal line editor
// Input word channel, result word channel and capacity write channel.
// ----------------------------------------------------------------------------
interface tle_in_if;
    import tle_pkg::*;
    logic       valid;
    logic       ready;
    t_cmd       cmd;
    logic [7:0] char_in;
    logic [7:0] read_index;

    modport source (output valid, cmd, char_in, read_index, input ready);
    modport sink   (input valid, cmd, char_in, read_index, output ready);
endinterface

interface tle_out_if;
    import tle_pkg::*;
    logic       valid;
    logic       ready;
    t_kind      kind;
    logic [7:0] data_byte;
    logic [7:0] line_length;
    t_reason    end_reason;
    logic       last;

    modport source (output valid, kind, data_byte, line_length, end_reason, last,
                    input ready);
    modport sink   (input valid, kind, data_byte, line_length, end_reason, last,
                    output ready);
endinterface

interface tle_cfg_if;
    import tle_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### design/terminal_line_editor_core.sv
// ----------------------------------------------------------------------------
// terminal_line_editor_core: canonical terminal line editor
// Edits received characters into a line store, emits echo words and
// line-complete words, and reads stored bytes back by index.
// ----------------------------------------------------------------------------
//
//  channel  | dir | word
//  ---------+-----+------------------------------------------------------
//  i_in     | in  | cmd, char_in, read_index
//  o_out    | out | kind, data_byte, line_length, end_reason, last
//  i_cfg    | in  | line_capacity (9 bits), always ready
//
//  An accepted word is held in the input register, then is processed in
//  one pass as soon as the result sequencer is free; it gives 0 to 6
//  result words, one per cycle while o_out is ready, and back-to-back
//  words overlap: the next word is taken while results of the previous
//  one still drain. The result sequencer sets the rate. The store read
//  for a read command issues at accept time through the memory's registered
//  read port. Reset (synchronous, active low) clears length, finished
//  flag, capacity (to 256) and the handshakes; the line store is not
//  cleared. A stalled o_out holds its word and the input register fills,
//  then i_in.ready drops.
//
module terminal_line_editor_core (
    input  logic i_clk,
    input  logic i_rst_n,
    tle_in_if.sink    i_in,
    tle_out_if.source o_out,
    tle_cfg_if.sink   i_cfg
);
    import tle_pkg::*;

    typedef enum logic [2:0] {
        SEQ_APPEND,
        SEQ_READ,
        SEQ_ENTER,
        SEQ_INTR,
        SEQ_EOF,
        SEQ_BS,
        SEQ_CANCEL
    } t_seq;

    // Line store: first HEAD_N bytes in flops (the exit text lands there in
    // one pass), the rest in a single-port-write memory.
    logic [7:0]        r_mem [LINE_DEPTH];
    logic [7:0]        r_head [HEAD_N];
    logic [7:0]        r_rd_data;

    logic [LEN_W-1:0]  r_len;
    logic              r_fin;
    logic [CAP_W-1:0]  r_cap;

    // Input register
    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [7:0]        r_char;
    logic [7:0]        r_idx;

    // Result sequencer
    logic              r_out_valid;
    t_seq              r_seq;
    logic [2:0]        r_step;
    logic [7:0]        r_byte;
    logic [7:0]        r_len_out;

    logic              in_acc;
    logic              out_acc;
    logic              seq_last;
    logic              free;
    logic              move;

    logic [LEN_W-1:0]  cap_eff;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  exit_n;
    logic [LEN_W-1:0]  n_len;
    logic              n_fin;
    logic              has_res;
    t_seq              n_seq;
    logic [7:0]        n_byte;
    logic              exit_wr;
    logic              app_wr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_byte;
    logic [2:0]        seq_cnt;

    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_acc     = r_out_valid && o_out.ready;
    assign free        = !r_out_valid || (out_acc && seq_last);
    assign move        = r_in_valid && free;
    assign i_in.ready  = !r_in_valid || free;
    assign rd_addr     = ADDR_W'(i_in.read_index);
    assign wr_addr     = ADDR_W'(cur_len);

    // Clamp capacity into 1..LINE_DEPTH
    always_comb begin
        if (32'(r_cap) > 32'(LINE_DEPTH)) begin
            cap_eff = LEN_W'(LINE_DEPTH);
        end else if (r_cap == '0) begin
            cap_eff = LEN_W'(1);
        end else begin
            cap_eff = LEN_W'(r_cap);
        end
        exit_n = (cap_eff - LEN_W'(1) > LEN_W'(HEAD_N)) ? LEN_W'(HEAD_N)
                                                        : cap_eff - LEN_W'(1);
    end

    // A finished line is discarded by the next character or cancel.
    assign cur_len = r_fin ? '0 : r_len;

    // Read data: zero at or beyond the length.
    always_comb begin
        rd_byte = 8'd0;
        if (32'(r_idx) < 32'(r_len)) begin
            if (32'(r_idx) < 32'(HEAD_N)) begin
                rd_byte = r_head[r_idx[1:0]];
            end else begin
                rd_byte = r_rd_data;
            end
        end
    end

    // Single-pass edit of the word in the input register
    always_comb begin
        n_len   = r_len;
        n_fin   = r_fin;
        has_res = 1'b0;
        n_seq   = SEQ_READ;
        n_byte  = 8'd0;
        exit_wr = 1'b0;
        app_wr  = 1'b0;
        case (r_cmd)
            CMD_READ: begin
                has_res = 1'b1;
                n_seq   = SEQ_READ;
                n_byte  = rd_byte;
            end
            CMD_CANCEL: begin
                exit_wr = 1'b1;
                n_len   = exit_n;
                n_fin   = 1'b1;
                has_res = 1'b1;
                n_seq   = SEQ_CANCEL;
            end
            CMD_CHAR: begin
                n_len = cur_len;
                n_fin = 1'b0;
                if (r_char == CH_CR || r_char == CH_LF) begin
                    n_fin   = 1'b1;
                    has_res = 1'b1;
                    n_seq   = SEQ_ENTER;
                end else if (r_char == CH_ETX) begin
                    n_len   = '0;
                    n_fin   = 1'b1;
                    has_res = 1'b1;
                    n_seq   = SEQ_INTR;
                end else if (r_char == CH_EOT && cur_len == '0) begin
                    exit_wr = 1'b1;
                    n_len   = exit_n;
                    n_fin   = 1'b1;
                    has_res = 1'b1;
                    n_seq   = SEQ_EOF;
                end else if (r_char == CH_BS) begin
                    if (cur_len != '0) begin
                        n_len   = cur_len - LEN_W'(1);
                        has_res = 1'b1;
                        n_seq   = SEQ_BS;
                    end
                end else if (r_char >= CH_SPACE && r_char <= CH_TILDE &&
                             cur_len + LEN_W'(1) < cap_eff) begin
                    app_wr  = 1'b1;
                    n_len   = cur_len + LEN_W'(1);
                    has_res = 1'b1;
                    n_seq   = SEQ_APPEND;
                    n_byte  = r_char;
                end
            end
            default: begin
                // read error: drop
            end
        endcase
    end

    // Line store memory; forward a same-edge append to the read port.
    always_ff @(posedge i_clk) begin
        if (move && app_wr) begin
            r_mem[wr_addr] <= r_char;
        end
        if (in_acc) begin
            if (move && app_wr && wr_addr == rd_addr) begin
                r_rd_data <= r_char;
            end else begin
                r_rd_data <= r_mem[rd_addr];
            end
        end
    end

    // Head bytes of the line store
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HEAD_N; i++) begin
            if (move && exit_wr && 32'(i) < 32'(exit_n)) begin
                r_head[i] <= EXIT_WORD[i];
            end else if (move && app_wr && 32'(cur_len) == 32'(i)) begin
                r_head[i] <= r_char;
            end
        end
    end

    // Control state and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_fin       <= 1'b0;
            r_cap       <= CAP_W'(256);
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seq       <= SEQ_READ;
            r_step      <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
            // input register: fill on accept, empty when processed
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            // result sequencer: advance on each taken word
            if (move) begin
                r_len       <= n_len;
                r_fin       <= n_fin;
                r_out_valid <= has_res;
                r_seq       <= n_seq;
                r_step      <= '0;
            end else if (out_acc) begin
                if (seq_last) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_in.cmd;
            r_char <= i_in.char_in;
            r_idx  <= i_in.read_index;
        end
        if (move) begin
            r_byte    <= n_byte;
            r_len_out <= 8'(n_len);
        end
    end

    // Result word decode from sequence and step
    always_comb begin
        case (r_seq)
            SEQ_APPEND: seq_cnt = 3'd1;
            SEQ_READ:   seq_cnt = 3'd1;
            SEQ_ENTER:  seq_cnt = 3'd2;
            SEQ_INTR:   seq_cnt = 3'd4;
            SEQ_EOF:    seq_cnt = 3'd6;
            SEQ_BS:     seq_cnt = 3'd3;
            SEQ_CANCEL: seq_cnt = 3'd1;
            default:    seq_cnt = 3'd1;
        endcase
    end

    assign seq_last = (r_step == seq_cnt - 3'd1);

    always_comb begin
        o_out.valid       = r_out_valid;
        o_out.last        = seq_last;
        o_out.kind        = KIND_ECHO;
        o_out.data_byte   = 8'd0;
        o_out.line_length = 8'd0;
        o_out.end_reason  = END_ENTER;
        if (seq_last && r_seq != SEQ_APPEND && r_seq != SEQ_READ &&
            r_seq != SEQ_BS) begin
            o_out.kind        = KIND_LINE;
            o_out.line_length = r_len_out;
        end
        case (r_seq)
            SEQ_APPEND: begin
                o_out.data_byte = r_byte;
            end
            SEQ_READ: begin
                o_out.kind      = KIND_RDATA;
                o_out.data_byte = r_byte;
            end
            SEQ_ENTER: begin
                if (!seq_last) begin
                    o_out.data_byte = CH_LF;
                end
            end
            SEQ_INTR: begin
                o_out.end_reason  = seq_last ? END_INTR : END_ENTER;
                o_out.line_length = 8'd0;
                case (r_step)
                    3'd0:    o_out.data_byte = CH_CARET;
                    3'd1:    o_out.data_byte = CH_C;
                    3'd2:    o_out.data_byte = CH_LF;
                    default: o_out.data_byte = 8'd0;
                endcase
            end
            SEQ_EOF: begin
                o_out.end_reason = seq_last ? END_EXIT : END_ENTER;
                case (r_step)
                    3'd0:    o_out.data_byte = EXIT_WORD[0];
                    3'd1:    o_out.data_byte = EXIT_WORD[1];
                    3'd2:    o_out.data_byte = EXIT_WORD[2];
                    3'd3:    o_out.data_byte = EXIT_WORD[3];
                    3'd4:    o_out.data_byte = CH_LF;
                    default: o_out.data_byte = 8'd0;
                endcase
            end
            SEQ_BS: begin
                o_out.data_byte = (r_step == 3'd1) ? CH_SPACE : CH_BS;
            end
            SEQ_CANCEL: begin
                o_out.end_reason = END_CANCEL;
            end
            default: begin
                o_out.data_byte = 8'd0;
            end
        endcase
    end

endmodule
